// File: design/assert_macros.svh
// Assertion helpers included by tabulation_hash_engine.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define TBH_ASSERT(lbl, prop, msg)

`define TBH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/tbh_pkg.sv
package tbh_pkg;

  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned SYMBOL_BITS   = 8;
  localparam int unsigned MAX_HASH_BITS = 64;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned TAB_W   = 3;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned NTAB_W  = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned DEPTH   = 1 << SYMBOL_BITS;

  localparam int unsigned KEY_LIMIT =
      (KEY_W < MAX_KEY_BYTES * 8) ? KEY_W : MAX_KEY_BYTES * 8;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_HASH  = 1'b1;

  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_BITS  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HASH_BITS = 1'b1;

  typedef struct packed {
    logic                   valid;
    logic                   action;
    logic [KEY_W-1:0]       key;
    logic [TAB_W-1:0]       table_index;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [WORD_W-1:0]      entry_value;
    logic [WORD_W-1:0]      acc;
  } item_t;

  typedef struct packed {
    logic                   active;
    logic [SYMBOL_BITS-1:0] sym_mask;
  } cell_cfg_t;

endpackage

// File: design/tbh_cell.sv
module tbh_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [tbh_pkg::TAB_W-1:0] cell_idx_i,
  input  tbh_pkg::cell_cfg_t        cfg_i,
  input  tbh_pkg::item_t            item_i,
  output tbh_pkg::item_t            item_o
);

  logic [tbh_pkg::WORD_W-1:0]      mem_q [tbh_pkg::DEPTH];
  logic [tbh_pkg::WORD_W-1:0]      rdata_q;
  logic                            hit_q;
  logic                            valid_q;
  tbh_pkg::item_t                  item_q;
  logic [tbh_pkg::SYMBOL_BITS-1:0] rd_addr;
  logic                            rd_en;
  logic                            wr_en;

  assign rd_addr = item_i.key[tbh_pkg::SYMBOL_BITS-1:0] & cfg_i.sym_mask;
  assign rd_en   = item_i.valid && (item_i.action == tbh_pkg::ACT_HASH) && cfg_i.active;
  assign wr_en   = item_i.valid && (item_i.action == tbh_pkg::ACT_WRITE) &&
                   (item_i.table_index == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_i;
      hit_q  <= rd_en;
      if (rd_en) begin
        rdata_q <= mem_q[rd_addr];
      end
      if (wr_en) begin
        mem_q[item_i.symbol] <= item_i.entry_value;
      end
    end
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
    item_o.key   = item_q.key >> tbh_pkg::SYMBOL_BITS;
    item_o.acc   = hit_q ? (item_q.acc ^ rdata_q) : item_q.acc;
  end

endmodule

// File: design/tabulation_hash_engine.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   action, key, table_index, symbol, entry_value
// out       output     out_valid_o/out_ready_i hash_value
// cfg       input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// An item passes through one table cell per cycle while the output is not stalled,
// then through the output register to give a hash result; a write item gives no result.
// A new item can be accepted every cycle while the output is not stalled.
// When the output register holds an item that is not taken, the whole chain stalls.
// Reset clears the valid flags and sets both configuration registers to 64;
// table contents stay undefined.

`include "assert_macros.svh"

module tabulation_hash_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            action_i,
  input  logic [tbh_pkg::KEY_W-1:0]       key_i,
  input  logic [tbh_pkg::TAB_W-1:0]       table_index_i,
  input  logic [tbh_pkg::SYMBOL_BITS-1:0] symbol_i,
  input  logic [tbh_pkg::WORD_W-1:0]      entry_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tbh_pkg::WORD_W-1:0]      hash_value_o,
  input  logic                            cfg_we_i,
  input  logic [tbh_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tbh_pkg::CFG_W-1:0]       cfg_data_i
);

  logic [tbh_pkg::CFG_W-1:0]  key_bits_q;
  logic [tbh_pkg::CFG_W-1:0]  hash_bits_q;
  logic [tbh_pkg::CFG_W-1:0]  kb;
  logic [tbh_pkg::CFG_W-1:0]  hb;
  logic [tbh_pkg::NTAB_W-1:0] ntab;
  logic [2:0]                 rem;
  logic [tbh_pkg::WORD_W-1:0] hmask;
  logic                       adv;
  logic                       out_valid_q;
  logic                       out_valid_d;
  logic [tbh_pkg::WORD_W-1:0] hash_q;
  tbh_pkg::item_t             chain [tbh_pkg::MAX_KEY_BYTES + 1];
  tbh_pkg::cell_cfg_t         cell_cfg [tbh_pkg::MAX_KEY_BYTES];
  tbh_pkg::item_t             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bits_q  <= tbh_pkg::CFG_W'(64);
      hash_bits_q <= tbh_pkg::CFG_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbh_pkg::REG_KEY_BITS:  key_bits_q  <= cfg_data_i;
        tbh_pkg::REG_HASH_BITS: hash_bits_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (key_bits_q == '0) begin
      kb = tbh_pkg::CFG_W'(1);
    end else if (key_bits_q > tbh_pkg::CFG_W'(tbh_pkg::KEY_LIMIT)) begin
      kb = tbh_pkg::CFG_W'(tbh_pkg::KEY_LIMIT);
    end else begin
      kb = key_bits_q;
    end
    if (hash_bits_q == '0) begin
      hb = tbh_pkg::CFG_W'(1);
    end else if (hash_bits_q > tbh_pkg::CFG_W'(tbh_pkg::MAX_HASH_BITS)) begin
      hb = tbh_pkg::CFG_W'(tbh_pkg::MAX_HASH_BITS);
    end else begin
      hb = hash_bits_q;
    end
  end

  assign ntab  = tbh_pkg::NTAB_W'(({1'b0, kb} + 8'd7) >> 3);
  assign rem   = kb[2:0];
  assign hmask = {tbh_pkg::WORD_W{1'b1}} >> (tbh_pkg::CFG_W'(tbh_pkg::WORD_W) - hb);

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    chain[0].valid       = in_valid_i;
    chain[0].action      = action_i;
    chain[0].key         = key_i;
    chain[0].table_index = table_index_i;
    chain[0].symbol      = symbol_i;
    chain[0].entry_value = entry_value_i;
    chain[0].acc         = '0;
  end

  for (genvar g = 0; g < tbh_pkg::MAX_KEY_BYTES; g++) begin : g_cell
    logic is_last;

    assign is_last                = (tbh_pkg::NTAB_W'(g + 1) == ntab);
    assign cell_cfg[g].active     = (tbh_pkg::NTAB_W'(g) < ntab);
    assign cell_cfg[g].sym_mask   = (is_last && rem != 3'd0) ?
                                    ~({tbh_pkg::SYMBOL_BITS{1'b1}} << rem) :
                                    {tbh_pkg::SYMBOL_BITS{1'b1}};

    tbh_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (tbh_pkg::TAB_W'(g)),
      .cfg_i      (cell_cfg[g]),
      .item_i     (chain[g]),
      .item_o     (chain[g + 1])
    );
  end

  assign last = chain[tbh_pkg::MAX_KEY_BYTES];

  assign out_valid_d = adv ? (last.valid && last.action == tbh_pkg::ACT_HASH) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hash_q <= last.acc & hmask;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  `TBH_ASSERT(a_out_from_hash, $rose(out_valid_o) |-> $past(last.valid && last.action == tbh_pkg::ACT_HASH), "result without a hash item")
  `TBH_ASSERT(a_chain_holds, !adv |=> $stable(last.valid), "chain moved while stalled")
  `TBH_ASSERT(a_hash_masked, out_valid_o |-> ((hash_value_o & ~hmask) == '0), "hash bits above hash_bits set")

endmodule
